// ===== hw/rtl/irsa_pkg.sv =====
// Package for the integer RPN stack ALU: opcodes, widths, queue entry type.
// No dependencies.
`default_nettype none
package irsa_pkg;
    localparam int STACK_DEPTH = 4;
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 5;

    localparam logic [MODE_W-1:0] OP_PUSH    = 5'd0;
    localparam logic [MODE_W-1:0] OP_SETTOP  = 5'd1;
    localparam logic [MODE_W-1:0] OP_POP     = 5'd2;
    localparam logic [MODE_W-1:0] OP_DUP     = 5'd3;
    localparam logic [MODE_W-1:0] OP_SWAP    = 5'd4;
    localparam logic [MODE_W-1:0] OP_ROTPOP  = 5'd5;
    localparam logic [MODE_W-1:0] OP_ROTPUSH = 5'd6;
    localparam logic [MODE_W-1:0] OP_UNDO    = 5'd7;
    localparam logic [MODE_W-1:0] OP_ADD     = 5'd8;
    localparam logic [MODE_W-1:0] OP_SUB     = 5'd9;
    localparam logic [MODE_W-1:0] OP_MUL     = 5'd10;
    localparam logic [MODE_W-1:0] OP_DIV     = 5'd11;
    localparam logic [MODE_W-1:0] OP_NEG     = 5'd12;
    localparam logic [MODE_W-1:0] OP_OR      = 5'd13;
    localparam logic [MODE_W-1:0] OP_XOR     = 5'd14;
    localparam logic [MODE_W-1:0] OP_AND     = 5'd15;
    localparam logic [MODE_W-1:0] OP_SHL     = 5'd16;
    localparam logic [MODE_W-1:0] OP_SHR     = 5'd17;
    localparam logic [MODE_W-1:0] OP_NOT     = 5'd18;

    // Classified request handed from front to back.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] value;
        logic              valid_op;  // mode in range and not undo, undo store is written
        logic              is_div;
    } t_req;
endpackage
`default_nettype wire

// ===== hw/rtl/irsa_front.sv =====
// Front end: takes commands, classifies them, and holds a two-entry queue.
// Depends on irsa_pkg.
`default_nettype none
module irsa_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [4:0]      i_mode,
    input  wire logic [31:0]     i_value,
    output logic                 o_full,
    output logic                 o_empty,
    output irsa_pkg::t_req       o_req,
    input  wire logic            i_pop
);
    import irsa_pkg::*;

    t_req       r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_req       w_in;
    logic       w_push;

    always_comb begin
        w_in.mode     = i_mode;
        w_in.value    = i_value;
        w_in.valid_op = (i_mode <= OP_NOT) && (i_mode != OP_UNDO);
        w_in.is_div   = (i_mode == OP_DIV);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_req   = r_q[r_rp];
    assign w_push  = i_start && !o_full;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ (i_pop && !o_empty);
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, (i_pop && !o_empty)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/irsa_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Depends on irsa_pkg.
`default_nettype none
module irsa_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [31:0] i_y,
    input  wire logic [31:0] i_x,
    output logic             o_done,
    output logic [31:0]      o_q
);
    import irsa_pkg::*;

    logic [31:0] r_rem, r_quo, r_div;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [32:0] w_trial;
    logic [31:0] w_ay, w_ax;

    assign w_ay    = i_y[31] ? (32'd0 - i_y) : i_y;
    assign w_ax    = i_x[31] ? (32'd0 - i_x) : i_x;
    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_div};
    assign o_q     = r_neg ? (32'd0 - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_go) begin
            r_rem <= 32'd0;
            r_quo <= w_ay;
            r_div <= w_ax;
            r_neg <= i_y[31] ^ i_x[31];
        end else if (r_busy) begin
            // shift in next dividend bit, keep the difference if it fits
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/irsa_back.sv =====
// Back end: stack, undo store, ALU and result register.
// Depends on irsa_pkg and irsa_div.
`default_nettype none
module irsa_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire irsa_pkg::t_req  i_req,
    output logic                 o_pop,
    output logic                 o_idle,
    output logic                 o_valid,
    output logic [31:0]          o_top_value,
    output logic [31:0]          o_second_value,
    output logic [31:0]          o_removed_value,
    output logic                 o_div_zero
);
    import irsa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [31:0] r_stk [STACK_DEPTH];
    logic [31:0] r_undo [STACK_DEPTH];
    logic [31:0] n_stk [STACK_DEPTH];
    logic [1:0]  r_st, n_st;
    t_req        r_cur;
    logic signed [63:0] r_prod;
    logic        w_div_done;
    logic [31:0] w_div_q;
    logic        w_div_go;
    logic [31:0] w_res;
    logic        w_fin, w_dz;
    logic [31:0] w_x, w_y;

    assign w_x = r_stk[0];
    assign w_y = r_stk[1];

    irsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_div_go),
        .i_y     (w_y),
        .i_x     (w_x),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    assign o_idle   = (r_st == ST_IDLE);
    assign o_pop    = o_idle && !i_empty;
    assign w_div_go = o_pop && i_req.is_div && (r_stk[0] != 32'd0);

    // Result of current command; ops done in ST_IDLE use i_req, long ops r_cur.
    always_comb begin
        t_req  c;
        logic [31:0] shv;
        logic  shok;
        c     = o_idle ? i_req : r_cur;
        w_res = 32'd0;
        w_dz  = 1'b0;
        shok  = (w_x[31:5] == 27'd0);
        shv   = 32'd0;
        n_st  = r_st;
        w_fin = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++) n_stk[i] = r_stk[i];
        unique case (r_st)
            ST_IDLE: begin
                if (o_pop) begin
                    w_fin = 1'b1;
                    case (c.mode)
                        OP_PUSH, OP_DUP, OP_ROTPUSH: begin
                            for (int i = STACK_DEPTH - 1; i > 0; i--)
                                n_stk[i] = r_stk[i-1];
                            n_stk[0] = (c.mode == OP_PUSH) ? c.value :
                                       (c.mode == OP_DUP) ? r_stk[0] :
                                       r_stk[STACK_DEPTH-1];
                        end
                        OP_SETTOP: n_stk[0] = c.value;
                        OP_POP, OP_ROTPOP: begin
                            for (int i = 0; i < STACK_DEPTH - 1; i++)
                                n_stk[i] = r_stk[i+1];
                            if (c.mode == OP_ROTPOP)
                                n_stk[STACK_DEPTH-1] = r_stk[0];
                        end
                        OP_SWAP: begin
                            n_stk[0] = r_stk[1];
                            n_stk[1] = r_stk[0];
                        end
                        OP_UNDO: begin
                            for (int i = 0; i < STACK_DEPTH; i++)
                                n_stk[i] = r_undo[i];
                        end
                        OP_NEG, OP_NOT: begin
                            n_stk[0] = (c.mode == OP_NEG) ? (32'd0 - w_x) : ~w_x;
                        end
                        OP_ADD, OP_SUB, OP_OR, OP_XOR, OP_AND, OP_SHL, OP_SHR: begin
                            if (shok) shv = (c.mode == OP_SHL) ? (w_y << w_x[4:0])
                                                                : (w_y >> w_x[4:0]);
                            case (c.mode)
                                OP_ADD:  w_res = w_y + w_x;
                                OP_SUB:  w_res = w_y - w_x;
                                OP_OR:   w_res = w_y | w_x;
                                OP_XOR:  w_res = w_y ^ w_x;
                                OP_AND:  w_res = w_y & w_x;
                                default: w_res = shv;
                            endcase
                            for (int i = 1; i < STACK_DEPTH - 1; i++)
                                n_stk[i] = r_stk[i+1];
                            n_stk[0] = w_res;
                        end
                        OP_MUL: begin
                            w_fin = 1'b0;
                            n_st  = ST_MUL;
                        end
                        OP_DIV: begin
                            if (r_stk[0] == 32'd0) begin
                                w_dz = 1'b1;
                                for (int i = 1; i < STACK_DEPTH - 1; i++)
                                    n_stk[i] = r_stk[i+1];
                                n_stk[0] = 32'hFFFF_FFFF;
                            end else begin
                                w_fin = 1'b0;
                                n_st  = ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                w_fin = 1'b1;
                n_st  = ST_IDLE;
                if (r_prod > 64'sh7FFF_FFFF)       w_res = 32'h7FFF_FFFF;
                else if (r_prod < -64'sh8000_0000) w_res = 32'h8000_0000;
                else                               w_res = r_prod[31:0];
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_fin = 1'b1;
                    n_st  = ST_IDLE;
                    w_res = w_div_q;
                end
            end
            default: n_st = ST_IDLE;
        endcase
        if (r_st != ST_IDLE && w_fin) begin
            for (int i = 1; i < STACK_DEPTH - 1; i++)
                n_stk[i] = r_stk[i+1];
            n_stk[0] = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            o_valid <= 1'b0;
            for (int i = 0; i < STACK_DEPTH; i++) begin
                r_stk[i]  <= 32'd0;
                r_undo[i] <= 32'd0;
            end
        end else begin
            r_st    <= n_st;
            o_valid <= w_fin;
            for (int i = 0; i < STACK_DEPTH; i++) r_stk[i] <= n_stk[i];
            // snapshot on acceptance; long ops leave the stack untouched until done
            if (o_pop && i_req.valid_op) begin
                for (int i = 0; i < STACK_DEPTH; i++) r_undo[i] <= r_stk[i];
            end
        end
        if (o_pop) begin
            r_cur           <= i_req;
            o_removed_value <= r_stk[0];
            r_prod          <= $signed(w_y) * $signed(w_x);
        end
        if (w_fin) begin
            o_top_value    <= n_stk[0];
            o_second_value <= n_stk[1];
            o_div_zero     <= w_dz;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/integer_rpn_stack_alu.sv =====
// Integer RPN stack ALU with single-level undo.
// Most ops and divide by zero finish in the back end's idle state; multiply
// passes through ST_MUL, divide waits in ST_DIV for the radix-2 divider.
// busy is high while the two-entry queue is full. Results strobe on o_valid
// for one cycle; the receiver cannot stall them.
// Synchronous active-low reset clears the stack and undo store to zero.
`default_nettype none
module integer_rpn_stack_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [4:0]  i_mode,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    output logic [31:0]      o_top_value,
    output logic [31:0]      o_second_value,
    output logic [31:0]      o_removed_value,
    output logic             o_div_zero
);
    import irsa_pkg::*;

    t_req w_req;
    logic w_empty, w_pop, w_idle;

    irsa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_value (i_value),
        .o_full  (busy),
        .o_empty (w_empty),
        .o_req   (w_req),
        .i_pop   (w_pop)
    );

    irsa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_req           (w_req),
        .o_pop           (w_pop),
        .o_idle          (w_idle),
        .o_valid         (o_valid),
        .o_top_value     (o_top_value),
        .o_second_value  (o_second_value),
        .o_removed_value (o_removed_value),
        .o_div_zero      (o_div_zero)
    );

    logic w_unused;
    assign w_unused = w_idle;
endmodule
`default_nettype wire

// ===== test/tb_integer_rpn_stack_alu.sv =====
// Testbench for integer_rpn_stack_alu: random and directed stack requests,
// results compared against a behavioral stack predictor. Depends on irsa_pkg.
`default_nettype none
module tb_integer_rpn_stack_alu;
    timeunit 1ns;
    timeprecision 1ps;
    import irsa_pkg::*;

    typedef struct {
        logic [31:0] top_v;
        logic [31:0] second_v;
        logic [31:0] removed_v;
        logic        dz;
    } t_calc_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [4:0]  i_mode = '0;
    logic [31:0] i_value = '0;
    logic        busy, o_valid, o_div_zero;
    logic [31:0] o_top_value, o_second_value, o_removed_value;

    logic [31:0] calc_stack [STACK_DEPTH];
    logic [31:0] calc_undo [STACK_DEPTH];
    t_calc_out   pending_q[$];
    int          n_errors = 0;
    longint      cycle_cnt = 0;

    integer_rpn_stack_alu dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        n_errors++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp_v, cycle_cnt);
    endtask

    // Check each result strobe against the oldest prediction.
    always @(posedge i_clk) begin
        t_calc_out e;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                report("unexpected result", o_top_value, 32'h0);
            end else begin
                e = pending_q.pop_front();
                if (o_top_value !== e.top_v) report("top", o_top_value, e.top_v);
                if (o_second_value !== e.second_v) report("second", o_second_value, e.second_v);
                if (o_removed_value !== e.removed_v)
                    report("removed", o_removed_value, e.removed_v);
                if (o_div_zero !== e.dz)
                    report("div_zero", {31'd0, o_div_zero}, {31'd0, e.dz});
            end
        end
    end

    function automatic void stack_push(input logic [31:0] v);
        for (int i = STACK_DEPTH - 1; i > 0; i--) calc_stack[i] = calc_stack[i-1];
        calc_stack[0] = v;
    endfunction

    function automatic logic [31:0] stack_pop();
        logic [31:0] t;
        t = calc_stack[0];
        for (int i = 0; i + 1 < STACK_DEPTH; i++) calc_stack[i] = calc_stack[i+1];
        return t;
    endfunction

    function automatic logic [31:0] apply_binary(input logic [4:0] m, input logic [31:0] y,
                                                 input logic [31:0] x, inout logic dz);
        longint p;
        logic signed [31:0] sx, sy;
        sx = x;
        sy = y;
        case (m)
            OP_ADD: return y + x;
            OP_SUB: return y - x;
            OP_MUL: begin
                p = longint'(sy) * longint'(sx);
                if (p > 64'sd2147483647) p = 64'sd2147483647;
                if (p < -64'sd2147483648) p = -64'sd2147483648;
                return p[31:0];
            end
            OP_DIV: begin
                if (x == 0) begin
                    dz = 1'b1;
                    return 32'hFFFF_FFFF;
                end
                p = longint'(sy) / longint'(sx);
                return p[31:0];
            end
            OP_OR:  return y | x;
            OP_XOR: return y ^ x;
            OP_AND: return y & x;
            OP_SHL: return (sx < 0 || sx >= 32) ? 32'h0 : y << sx[4:0];
            default: return (sx < 0 || sx >= 32) ? 32'h0 : y >> sx[4:0];
        endcase
    endfunction

    function automatic t_calc_out predict_stack(input logic [4:0] m, input logic [31:0] v);
        t_calc_out r;
        logic [31:0] x, y;
        r.dz = 1'b0;
        r.removed_v = calc_stack[0];
        if (m <= OP_NOT && m != OP_UNDO) calc_undo = calc_stack;
        case (m)
            OP_PUSH:    stack_push(v);
            OP_SETTOP:  calc_stack[0] = v;
            OP_POP:     x = stack_pop();
            OP_DUP:     stack_push(calc_stack[0]);
            OP_SWAP: begin
                x = stack_pop();
                y = stack_pop();
                stack_push(x);
                stack_push(y);
            end
            OP_ROTPOP: begin
                x = stack_pop();
                calc_stack[STACK_DEPTH-1] = x;
            end
            OP_ROTPUSH: stack_push(calc_stack[STACK_DEPTH-1]);
            OP_UNDO:    calc_stack = calc_undo;
            OP_NEG: begin
                x = stack_pop();
                stack_push(-x);
            end
            OP_NOT: begin
                x = stack_pop();
                stack_push(~x);
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_OR, OP_XOR, OP_AND, OP_SHL, OP_SHR: begin
                x = stack_pop();
                y = stack_pop();
                stack_push(apply_binary(m, y, x, r.dz));
            end
            default: ;
        endcase
        r.top_v = calc_stack[0];
        r.second_v = calc_stack[1];
        return r;
    endfunction

    // Send one request; gaps before it are mostly short, now and then long.
    // Start stays high straight into the next request when there is no gap.
    task automatic send_request(input logic [4:0] m, input logic [31:0] v);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_mode <= m;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        pending_q.push_back(predict_stack(m, v));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            6: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_special_cases();
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_ADD, 32'h0);
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_DUP, 32'h0);
        send_request(OP_MUL, 32'h0);
        send_request(OP_PUSH, 32'h0);
        send_request(OP_MUL, 32'h0);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_DIV, 32'h0);
        send_request(OP_PUSH, 32'h0);
        send_request(OP_DIV, 32'h0);
        send_request(OP_UNDO, 32'h0);
        send_request(OP_PUSH, 32'd32);
        send_request(OP_SHL, 32'h0);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_SHR, 32'h0);
        send_request(OP_SETTOP, 32'hA5A5_5A5A);
        send_request(OP_PUSH, 32'd31);
        send_request(OP_SHR, 32'h0);
        send_request(5'd19, 32'h0);
        send_request(5'd31, 32'hFFFF_FFFF);
    endtask

    task automatic test_every_op();
        for (int m = 0; m <= OP_NOT; m++) send_request(m[4:0], rand_operand());
    endtask

    task automatic test_random_mix();
        logic [4:0] m;
        for (int n = 0; n < 1400; n++) begin
            // Favor pushes so that arithmetic sees fresh operands.
            case ($urandom_range(0, 9))
                0, 1, 2: m = OP_PUSH;
                3:       m = 5'($urandom_range(19, 31));
                default: m = 5'($urandom_range(0, 18));
            endcase
            send_request(m, rand_operand());
        end
    endtask

    initial begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            calc_stack[i] = '0;
            calc_undo[i] = '0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_cases();
        test_every_op();
        test_random_mix();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== integer_rpn_stack_alu.f =====
hw/rtl/irsa_pkg.sv
hw/rtl/irsa_front.sv
hw/rtl/irsa_div.sv
hw/rtl/irsa_back.sv
hw/rtl/integer_rpn_stack_alu.sv
test/tb_integer_rpn_stack_alu.sv
